>>> rtl/core/eilc_pkg.sv
`timescale 1ns / 1ps

package eilc_pkg;

  localparam int unsigned LineW     = 16;
  localparam int unsigned NumPorts  = 5;
  localparam int unsigned CodeW     = 4;
  localparam int unsigned IrqW      = 7;
  localparam int unsigned AddrW     = 5;
  localparam int unsigned RegW      = 64;
  localparam int unsigned SDataW    = 96;
  localparam int unsigned MDataW    = 24;

  // interrupt output grouping
  localparam int unsigned SoloLines = 5;
  localparam int unsigned MidLo     = 5;
  localparam int unsigned MidHi     = 9;
  localparam int unsigned HighLo    = 10;
  localparam int unsigned HighHi    = 15;
  localparam int unsigned IrqMidBit  = 5;
  localparam int unsigned IrqHighBit = 6;

  typedef enum logic [CodeW-1:0] {
    PORT_A = 4'd0,
    PORT_B = 4'd1,
    PORT_C = 4'd2,
    PORT_D = 4'd3,
    PORT_E = 4'd4
  } port_code_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    REG_LINE_PORT_SELECT  = 2'd0,
    REG_RISING_ENABLE     = 2'd1,
    REG_FALLING_ENABLE    = 2'd2,
    REG_INTERRUPT_MASK    = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic sample;
    logic clear;
  } lane_ctrl_t;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic             rise_en;
    logic             fall_en;
  } lane_cfg_t;

  typedef struct packed {
    logic            pad;
    logic [IrqW-1:0] irq;
    logic [LineW-1:0] pending;
  } result_t;

endpackage

>>> rtl/core/eilc_lane.sv
`timescale 1ns / 1ps

module eilc_lane (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  eilc_pkg::lane_ctrl_t              ctrl_i,
  input  eilc_pkg::lane_cfg_t               cfg_i,
  input  logic [eilc_pkg::NumPorts-1:0]     port_bits_i,
  input  logic                              clear_bit_i,
  output logic                              pend_next_o
);

  logic level;
  logic last_q, last_d;
  logic pend_q, pend_d;

  always_comb begin
    case (cfg_i.code)
      eilc_pkg::PORT_A: level = port_bits_i[0];
      eilc_pkg::PORT_B: level = port_bits_i[1];
      eilc_pkg::PORT_C: level = port_bits_i[2];
      eilc_pkg::PORT_D: level = port_bits_i[3];
      eilc_pkg::PORT_E: level = port_bits_i[4];
      default:          level = 1'b0;
    endcase
  end

  always_comb begin
    last_d = last_q;
    pend_d = pend_q;
    if (ctrl_i.sample) begin
      last_d = level;
      pend_d = pend_q | (level & ~last_q & cfg_i.rise_en) | (~level & last_q & cfg_i.fall_en);
    end else if (ctrl_i.clear) begin
      pend_d = pend_q & ~clear_bit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      last_q <= last_d;
      pend_q <= pend_d;
    end
  end

  assign pend_next_o = pend_d;

`ifndef SYNTHESIS
  a_clear_keeps_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clear && !ctrl_i.sample |=> $stable(last_q))
    else $error("clear changed kept level");
  a_pend_falls_on_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(pend_q) |-> $past(ctrl_i.clear))
    else $error("pending dropped without clear");
  a_pend_rises_on_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pend_q) |-> $past(ctrl_i.sample))
    else $error("pending set without sample");
`endif

endmodule

>>> rtl/core/eilc_merge.sv
`timescale 1ns / 1ps

module eilc_merge (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic [eilc_pkg::LineW-1:0]    pend_i,
  input  logic [eilc_pkg::LineW-1:0]    mask_i,
  output logic                          s_ready_o,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output eilc_pkg::result_t             m_data_o
);

  logic [eilc_pkg::LineW-1:0] masked;
  eilc_pkg::result_t          res;
  eilc_pkg::result_t          main_q, skid_q;
  logic                       main_valid_q, skid_valid_q;
  logic                       pop;

  always_comb begin
    masked  = pend_i & mask_i;
    res     = '0;
    res.pending = pend_i;
    res.irq[eilc_pkg::SoloLines-1:0] = masked[eilc_pkg::SoloLines-1:0];
    res.irq[eilc_pkg::IrqMidBit]  = |masked[eilc_pkg::MidHi:eilc_pkg::MidLo];
    res.irq[eilc_pkg::IrqHighBit] = |masked[eilc_pkg::HighHi:eilc_pkg::HighLo];
  end

  assign pop       = main_valid_q & m_ready_i;
  assign s_ready_o = ~skid_valid_q;
  assign m_valid_o = main_valid_q;
  assign m_data_o  = main_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (main_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        main_valid_q <= 1'b1;
      end
    end else if (pop) begin
      main_valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (push_i) begin
      if (main_valid_q && !pop) begin
        skid_q <= res;
      end else begin
        main_q <= res;
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_needs_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid beat without main beat");
  a_skid_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(main_valid_q && !m_ready_i))
    else $error("skid filled without stall");
  a_push_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> s_ready_o)
    else $error("beat pushed while full");
  a_mid_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    main_valid_q && (main_q.pending[eilc_pkg::MidHi:eilc_pkg::MidLo] == '0)
      |-> !main_q.irq[eilc_pkg::IrqMidBit])
    else $error("shared interrupt without pending line");
`endif

endmodule

>>> rtl/core/external_interrupt_line_controller_core.sv
`timescale 1ns / 1ps
// channel  | dir | beat content
// s_*      | in  | tdata: port_a, port_b, port_c, port_d, port_e, clear_mask; tuser: opcode
// m_*      | out | tdata: pending_flags, irq_lines, zero pad
// apb      | in  | 64-bit registers at byte address 8*i
//
// one beat per cycle sustained while the skid entry is free; results leave registered
// the per-line edge and pending update closes in the single accept cycle
// a two-entry output buffer keeps s_tready high through one stalled m beat
// reset clears kept levels, pending bits and all apb registers

module external_interrupt_line_controller_core #(
  parameter int unsigned NUM_LINES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // apb
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [eilc_pkg::AddrW-1:0]        paddr,
  input  logic [eilc_pkg::RegW-1:0]         pwdata,
  output logic [eilc_pkg::RegW-1:0]         prdata,
  output logic                              pready,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [eilc_pkg::SDataW-1:0]       s_tdata,  // port_a, b, c, d, e, clear_mask
  input  logic                              s_tuser,  // opcode
  // output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [eilc_pkg::MDataW-1:0]       m_tdata   // pending_flags, irq_lines, pad
);

  localparam int unsigned LW = eilc_pkg::LineW;

  logic [eilc_pkg::RegW-1:0] sel_q;
  logic [LW-1:0]             rise_q, fall_q, mask_q;
  logic                      wr_en;
  eilc_pkg::reg_idx_e        reg_idx;

  logic                          accept;
  eilc_pkg::lane_ctrl_t          ctrl;
  logic [eilc_pkg::NumPorts-1:0][LW-1:0] port_words;
  logic [LW-1:0]                 clear_mask;
  logic [LW-1:0]                 pend_next;
  eilc_pkg::result_t             out_res;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = eilc_pkg::reg_idx_e'(paddr[eilc_pkg::AddrW-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q  <= '0;
      rise_q <= '0;
      fall_q <= '0;
      mask_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        eilc_pkg::REG_LINE_PORT_SELECT: sel_q  <= pwdata;
        eilc_pkg::REG_RISING_ENABLE:    rise_q <= pwdata[LW-1:0];
        eilc_pkg::REG_FALLING_ENABLE:   fall_q <= pwdata[LW-1:0];
        eilc_pkg::REG_INTERRUPT_MASK:   mask_q <= pwdata[LW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      eilc_pkg::REG_LINE_PORT_SELECT: prdata = sel_q;
      eilc_pkg::REG_RISING_ENABLE:    prdata = {{(eilc_pkg::RegW-LW){1'b0}}, rise_q};
      eilc_pkg::REG_FALLING_ENABLE:   prdata = {{(eilc_pkg::RegW-LW){1'b0}}, fall_q};
      eilc_pkg::REG_INTERRUPT_MASK:   prdata = {{(eilc_pkg::RegW-LW){1'b0}}, mask_q};
      default:                        prdata = '0;
    endcase
  end

  assign accept      = s_tvalid & s_tready;
  assign ctrl.sample = accept & (s_tuser == eilc_pkg::OP_SAMPLE);
  assign ctrl.clear  = accept & (s_tuser == eilc_pkg::OP_CLEAR);
  assign port_words  = s_tdata[eilc_pkg::NumPorts*LW-1:0];
  assign clear_mask  = s_tdata[eilc_pkg::SDataW-1:eilc_pkg::NumPorts*LW];

  for (genvar g = 0; g < LW; g++) begin : g_lane
    if (g < NUM_LINES) begin : g_on
      eilc_pkg::lane_cfg_t           cfg;
      logic [eilc_pkg::NumPorts-1:0] bits;

      assign cfg.code    = sel_q[g*eilc_pkg::CodeW +: eilc_pkg::CodeW];
      assign cfg.rise_en = rise_q[g];
      assign cfg.fall_en = fall_q[g];
      for (genvar p = 0; p < eilc_pkg::NumPorts; p++) begin : g_bit
        assign bits[p] = port_words[p][g];
      end

      eilc_lane u_lane (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctrl_i      (ctrl),
        .cfg_i       (cfg),
        .port_bits_i (bits),
        .clear_bit_i (clear_mask[g]),
        .pend_next_o (pend_next[g])
      );
    end else begin : g_off
      assign pend_next[g] = 1'b0;
    end
  end

  eilc_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (accept),
    .pend_i    (pend_next),
    .mask_i    (mask_q),
    .s_ready_o (s_tready),
    .m_valid_o (m_tvalid),
    .m_ready_i (m_tready),
    .m_data_o  (out_res)
  );

  assign m_tdata = out_res;

endmodule
